>>> hw/rtl/box_blur_3x3_edge_normalized_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 box blur
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_NORMALIZED_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_NORMALIZED_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define BB3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BB3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Types, constants and the reciprocal table of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int PIX_W          = 8;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    // input row runs one or two rows past the frame while draining
    localparam int ROW_W          = 13;
    localparam int OUT_ROW_W      = 12;
    localparam int SUM_W          = 12;
    localparam int CNT_W          = 4;
    localparam int NUM_W          = 13;
    localparam int RECIP_SHIFT    = 18;
    localparam int RECIP_W        = 18;
    localparam int PROD_W         = NUM_W + RECIP_W;
    localparam int FIFO_DEPTH     = 8;
    localparam int FIFO_PTR_W     = 3;
    localparam int FIFO_CNT_W     = 4;

    localparam logic [FRAME_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [FRAME_HEIGHT_W-1:0] MAX_ROWS     = 13'd4096;

    // register indexes of the configuration port
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_FRAME_WIDTH  = 2'd0;
    localparam cfg_index_t REG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic [PIX_W-1:0] in_red;
        logic [PIX_W-1:0] in_green;
        logic [PIX_W-1:0] in_blue;
        logic             drain;
    } pixel_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic             frame_end;
    } blur_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pix_t;

    // one line store entry: pixel two rows up and pixel one row up
    typedef struct packed {
        pix_t upper;
        pix_t middle;
    } line_pair_t;

    // per-item control that rides along with the pixel
    typedef struct packed {
        logic emit;
        logic last;
        logic up_ok;
        logic down_ok;
        logic left_ok;
        logic right_ok;
    } step_ctl_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } chan_sum_t;

    // ceil(2^18 / (2*count)); exact floor division for numerators below 4600
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        case (count)
            4'd1:    r = 18'd131072;
            4'd2:    r = 18'd65536;
            4'd3:    r = 18'd43691;
            4'd4:    r = 18'd32768;
            4'd5:    r = 18'd26215;
            4'd6:    r = 18'd21846;
            4'd7:    r = 18'd18725;
            4'd8:    r = 18'd16384;
            4'd9:    r = 18'd14564;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/bb3_ctrl.sv
// ----------------------------------------------------------------------------
// bb3_ctrl
// Frame geometry registers, input/output position counters, edge flags and
// result credit toward the output queue.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_edge_normalized_assert.svh"

module bb3_ctrl #(
    parameter int  MAX_LINE_PIXELS = 1024,
    localparam int COL_W           = $clog2(MAX_LINE_PIXELS)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  bb3_pkg::cfg_index_t          cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                         pixel_valid,
    output logic                         pixel_stall,
    input  bb3_pkg::pixel_req_t          pixel,
    input  logic                         result_pop,
    output logic                         step,
    output logic [COL_W-1:0]             step_col,
    output bb3_pkg::pix_t                step_px,
    output bb3_pkg::step_ctl_t           step_ctl
);
    import bb3_pkg::*;

    localparam int WU_W = $clog2(MAX_LINE_PIXELS + 1);
    localparam logic [WU_W-1:0] MAX_W = WU_W'(MAX_LINE_PIXELS);

    logic [FRAME_WIDTH_W-1:0]  width_reg, width_next;
    logic [FRAME_HEIGHT_W-1:0] height_reg, height_next;
    logic [COL_W-1:0]          in_col_reg, in_col_next;
    logic [ROW_W-1:0]          in_row_reg, in_row_next;
    logic [COL_W-1:0]          out_col_reg, out_col_next;
    logic [OUT_ROW_W-1:0]      out_row_reg, out_row_next;
    logic [FIFO_CNT_W-1:0]     pending_reg, pending_next;

    logic [WU_W-1:0]           w_used;
    logic [FRAME_HEIGHT_W-1:0] h_used;
    logic [WU_W-1:0]           in_col_inc;
    logic [WU_W-1:0]           out_col_inc;
    logic                      cfg_write;
    logic                      cfg_hit;
    logic                      accept;
    logic                      frame_taken;
    logic                      emit;
    logic                      last;
    logic                      down_ok;
    logic                      right_ok;

    // clamp geometry to what the line stores and row range hold
    always_comb
    begin
        if (width_reg == '0)
            w_used = WU_W'(1);
        else if (32'(width_reg) > 32'(MAX_LINE_PIXELS))
            w_used = MAX_W;
        else
            w_used = WU_W'(width_reg);

        if (height_reg == '0)
            h_used = FRAME_HEIGHT_W'(1);
        else if (height_reg > MAX_ROWS)
            h_used = MAX_ROWS;
        else
            h_used = height_reg;
    end

    // request handshakes
    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign cfg_hit     = cfg_write &&
                         (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
    assign pixel_stall = pending_reg >= FIFO_CNT_W'(FIFO_DEPTH);
    assign accept      = pixel_valid && !pixel_stall;

    // item classification; drain before frame end is dropped
    assign frame_taken = in_row_reg >= ROW_W'(h_used);
    assign step        = accept && (frame_taken || !pixel.drain);
    assign emit        = (in_row_reg > ROW_W'(1)) ||
                         (in_row_reg == ROW_W'(1) && in_col_reg != '0);

    // neighbor availability of the pixel whose result is due
    assign in_col_inc  = WU_W'(in_col_reg) + 1'b1;
    assign out_col_inc = WU_W'(out_col_reg) + 1'b1;
    assign down_ok     = (FRAME_HEIGHT_W'(out_row_reg) + 1'b1) < h_used;
    assign right_ok    = out_col_inc < w_used;
    assign last        = !down_ok && !right_ok;

    // item sent down the pipe
    always_comb
    begin
        step_col          = in_col_reg;
        step_px           = frame_taken ? '0 : {pixel.in_red, pixel.in_green, pixel.in_blue};
        step_ctl.emit     = emit;
        step_ctl.last     = last;
        step_ctl.up_ok    = out_row_reg != '0;
        step_ctl.down_ok  = down_ok;
        step_ctl.left_ok  = out_col_reg != '0;
        step_ctl.right_ok = right_ok;
    end

    // counters, geometry and credit next state
    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pending_next = pending_reg + FIFO_CNT_W'(step && emit) - FIFO_CNT_W'(result_pop);

        if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_next  = cfg_data[FRAME_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: height_next = cfg_data[FRAME_HEIGHT_W-1:0];
                default:          ;
            endcase
        end

        if (cfg_hit)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (step)
        begin
            if (in_col_inc >= w_used)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_inc[COL_W-1:0];
            end

            if (emit)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (!right_ok)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pending_reg <= pending_next;
        end
    end

    `BB3_ASSERT_NOW(pending_bound, 1'b1, pending_reg <= FIFO_CNT_W'(FIFO_DEPTH), "result credit above queue depth")
    `BB3_ASSERT_NEXT(clear_after_last, step && emit && last && !cfg_hit, in_col_reg == '0 && in_row_reg == '0 && out_col_reg == '0 && out_row_reg == '0, "counters not cleared after frame end")

endmodule

>>> hw/rtl/bb3_line_mem.sv
// ----------------------------------------------------------------------------
// bb3_line_mem
// Two-row line store held as one memory of pixel pairs. Each item reads its
// column, and in the next cycle writes back the shifted pair. Same-cycle
// read/write to one column is forwarded.
// ----------------------------------------------------------------------------
module bb3_line_mem #(
    parameter int  MAX_LINE_PIXELS = 1024,
    localparam int COL_W           = $clog2(MAX_LINE_PIXELS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [COL_W-1:0]   step_col,
    input  bb3_pkg::pix_t      step_px,
    input  bb3_pkg::step_ctl_t step_ctl,
    output logic               tap_valid,
    output bb3_pkg::pix_t      tap_top,
    output bb3_pkg::pix_t      tap_mid,
    output bb3_pkg::pix_t      tap_px,
    output bb3_pkg::step_ctl_t tap_ctl
);
    import bb3_pkg::*;

    line_pair_t line_ram [MAX_LINE_PIXELS];

    line_pair_t rd_data_reg;
    logic       s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0] s1_col_reg;
    pix_t       s1_px_reg;
    step_ctl_t  s1_ctl_reg;
    logic       byp_hit_reg, byp_hit_next;
    line_pair_t byp_data_reg;

    line_pair_t cur;
    line_pair_t wr_data;

    // entry as seen by the item in stage one
    assign cur     = byp_hit_reg ? byp_data_reg : rd_data_reg;
    assign wr_data = {cur.middle, s1_px_reg};

    assign s1_valid_next = step;
    assign byp_hit_next  = step && s1_valid_reg && (step_col == s1_col_reg);

    // memory port: read on request, write back in the next cycle
    always_ff @(posedge clk)
    begin
        if (step)
            rd_data_reg <= line_ram[step_col];
        if (s1_valid_reg)
            line_ram[s1_col_reg] <= wr_data;
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        s1_col_reg   <= step_col;
        s1_px_reg    <= step_px;
        s1_ctl_reg   <= step_ctl;
        byp_data_reg <= wr_data;
    end

    // stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            byp_hit_reg  <= byp_hit_next;
        end
    end

    assign tap_valid = s1_valid_reg;
    assign tap_top   = cur.upper;
    assign tap_mid   = cur.middle;
    assign tap_px    = s1_px_reg;
    assign tap_ctl   = s1_ctl_reg;

endmodule

>>> hw/rtl/bb3_window.sv
// ----------------------------------------------------------------------------
// bb3_window
// 3x3 window of pixels, shifted one column per item, and the masked
// per-channel neighborhood sums and neighbor count.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_edge_normalized_assert.svh"

module bb3_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tap_valid,
    input  bb3_pkg::pix_t                 tap_top,
    input  bb3_pkg::pix_t                 tap_mid,
    input  bb3_pkg::pix_t                 tap_px,
    input  bb3_pkg::step_ctl_t            tap_ctl,
    output logic                          sum_valid,
    output bb3_pkg::chan_sum_t            sum,
    output logic [bb3_pkg::CNT_W-1:0]     count,
    output logic                          last
);
    import bb3_pkg::*;

    // index column*3 + row; row 0 is above, column 0 is left
    pix_t       win_reg [9];
    pix_t       win_next [9];
    logic       s2_valid_reg, s2_valid_next;
    step_ctl_t  s2_ctl_reg;
    logic       sum_valid_reg, sum_valid_next;
    chan_sum_t  sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic       last_reg;

    logic [2:0] col_ok;
    logic [2:0] row_ok;
    logic [8:0] tap_en;
    pix_t       masked [9];
    chan_sum_t  col_sum [3];

    // window shift
    always_comb
    begin
        for (int k = 0; k < 6; k++)
            win_next[k] = win_reg[k + 3];
        win_next[6] = tap_top;
        win_next[7] = tap_mid;
        win_next[8] = tap_px;
    end

    assign s2_valid_next = tap_valid && tap_ctl.emit;

    // neighbor mask from frame edges
    always_comb
    begin
        col_ok = {s2_ctl_reg.right_ok, 1'b1, s2_ctl_reg.left_ok};
        row_ok = {s2_ctl_reg.down_ok, 1'b1, s2_ctl_reg.up_ok};
        for (int dc = 0; dc < 3; dc++)
        begin
            for (int dr = 0; dr < 3; dr++)
            begin
                tap_en[dc * 3 + dr] = col_ok[dc] && row_ok[dr];
                masked[dc * 3 + dr] = tap_en[dc * 3 + dr] ? win_reg[dc * 3 + dr] : '0;
            end
        end
    end

    // column sums, then the total
    always_comb
    begin
        for (int dc = 0; dc < 3; dc++)
        begin
            col_sum[dc].red   = SUM_W'(masked[dc * 3].red) + SUM_W'(masked[dc * 3 + 1].red)
                              + SUM_W'(masked[dc * 3 + 2].red);
            col_sum[dc].green = SUM_W'(masked[dc * 3].green)
                              + SUM_W'(masked[dc * 3 + 1].green)
                              + SUM_W'(masked[dc * 3 + 2].green);
            col_sum[dc].blue  = SUM_W'(masked[dc * 3].blue) + SUM_W'(masked[dc * 3 + 1].blue)
                              + SUM_W'(masked[dc * 3 + 2].blue);
        end
        sum_next.red   = col_sum[0].red + col_sum[1].red + col_sum[2].red;
        sum_next.green = col_sum[0].green + col_sum[1].green + col_sum[2].green;
        sum_next.blue  = col_sum[0].blue + col_sum[1].blue + col_sum[2].blue;
        count_next     = CNT_W'($countones(tap_en));
    end

    assign sum_valid_next = s2_valid_reg;

    // window and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
            s2_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            if (tap_valid)
            begin
                for (int k = 0; k < 9; k++)
                    win_reg[k] <= win_next[k];
            end
            s2_valid_reg  <= s2_valid_next;
            sum_valid_reg <= sum_valid_next;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        s2_ctl_reg <= tap_ctl;
        sum_reg    <= sum_next;
        count_reg  <= count_next;
        last_reg   <= s2_ctl_reg.last;
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;
    assign count     = count_reg;
    assign last      = last_reg;

    `BB3_ASSERT_NOW(count_nonzero, sum_valid_reg, count_reg != '0, "neighbor count is zero")

endmodule

>>> hw/rtl/bb3_norm.sv
// ----------------------------------------------------------------------------
// bb3_norm
// Rounded mean per channel: (2*sum + count) / (2*count), done as a multiply
// by a per-count reciprocal from the package table.
// ----------------------------------------------------------------------------
module bb3_norm (
    input  bb3_pkg::chan_sum_t        sum,
    input  logic [bb3_pkg::CNT_W-1:0] count,
    input  logic                      last,
    output bb3_pkg::blur_req_t        result
);
    import bb3_pkg::*;

    logic [RECIP_W-1:0] rcp;

    // one channel: numerator times reciprocal, keep the integer byte
    function automatic logic [PIX_W-1:0] mean8(input logic [SUM_W-1:0] s,
                                               input logic [CNT_W-1:0] n,
                                               input logic [RECIP_W-1:0] r);
        logic [NUM_W-1:0]  num;
        logic [PROD_W-1:0] prod;
        num  = NUM_W'({s, 1'b0}) + NUM_W'(n);
        prod = PROD_W'(num) * PROD_W'(r);
        return prod[RECIP_SHIFT + PIX_W - 1:RECIP_SHIFT];
    endfunction

    assign rcp = recip(count);

    always_comb
    begin
        result.out_red   = mean8(sum.red, count, rcp);
        result.out_green = mean8(sum.green, count, rcp);
        result.out_blue  = mean8(sum.blue, count, rcp);
        result.frame_end = last;
    end

endmodule

>>> hw/rtl/box_blur_3x3_edge_normalized.sv
// Results: that of pixel (r,c) is registered and queued once the request after
// pixel (r+1,c) in raster order, or the matching drain request, is accepted.
// Throughput: 1 request per cycle, set by the line store's one read and one
// write-back port per cycle; the output queue holds 8 results before stalling.
// Reset: geometry 640x480, counters and window cleared; line stores not cleared.
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_normalized
// Streaming 3x3 box blur of RGB pixels with edge-normalized rounded mean and
// an output queue that decouples the result side.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_edge_normalized_assert.svh"

module box_blur_3x3_edge_normalized #(
    parameter int MAX_LINE_PIXELS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  bb3_pkg::cfg_index_t            cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           pixel_valid,
    output logic                           pixel_stall,
    input  bb3_pkg::pixel_req_t            pixel,
    output logic                           blur_valid,
    input  logic                           blur_stall,
    output bb3_pkg::blur_req_t             blur
);
    import bb3_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE_PIXELS);

    logic             step;
    logic [COL_W-1:0] step_col;
    pix_t             step_px;
    step_ctl_t        step_ctl;
    logic             tap_valid;
    pix_t             tap_top;
    pix_t             tap_mid;
    pix_t             tap_px;
    step_ctl_t        tap_ctl;
    logic             sum_valid;
    chan_sum_t        sum;
    logic [CNT_W-1:0] count;
    logic             last;
    blur_req_t        result;

    blur_req_t             fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] fifo_count_reg, fifo_count_next;
    logic                  fifo_push;
    logic                  fifo_pop;

    bb3_ctrl #(
        .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .result_pop  (fifo_pop),
        .step        (step),
        .step_col    (step_col),
        .step_px     (step_px),
        .step_ctl    (step_ctl)
    );

    bb3_line_mem #(
        .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
    ) u_line_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .step_col  (step_col),
        .step_px   (step_px),
        .step_ctl  (step_ctl),
        .tap_valid (tap_valid),
        .tap_top   (tap_top),
        .tap_mid   (tap_mid),
        .tap_px    (tap_px),
        .tap_ctl   (tap_ctl)
    );

    bb3_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_valid (tap_valid),
        .tap_top   (tap_top),
        .tap_mid   (tap_mid),
        .tap_px    (tap_px),
        .tap_ctl   (tap_ctl),
        .sum_valid (sum_valid),
        .sum       (sum),
        .count     (count),
        .last      (last)
    );

    bb3_norm u_norm (
        .sum    (sum),
        .count  (count),
        .last   (last),
        .result (result)
    );

    // output queue handshakes
    assign fifo_push  = sum_valid;
    assign blur_valid = fifo_count_reg != '0;
    assign fifo_pop   = blur_valid && !blur_stall;
    assign blur       = fifo_mem[rd_ptr_reg];

    // queue pointers and fill
    always_comb
    begin
        wr_ptr_next     = fifo_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next     = fifo_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fifo_count_next = fifo_count_reg + FIFO_CNT_W'(fifo_push) - FIFO_CNT_W'(fifo_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fifo_count_reg <= fifo_count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (fifo_push)
            fifo_mem[wr_ptr_reg] <= result;
    end

    `BB3_ASSERT_NOW(no_fifo_overflow, fifo_push, fifo_count_reg != FIFO_CNT_W'(FIFO_DEPTH), "result pushed into a full queue")

endmodule

>>> verif/tb_box_blur_3x3_edge_normalized.sv
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_edge_normalized
// Self-checking bench for the streaming 3x3 box blur. Each accepted pixel
// request runs through a scoreboard model of the line stores, window and
// counters. Every blur request is compared field by field with the oldest
// predicted result. Short hand-built frames cover single-pixel frames,
// ignored drains, pixels sent after the frame, back-to-back frames and writes
// to an unused register. The clamped geometry extremes and random frames
// follow, with random gaps on the pixel side and random stalls on the result
// side. The last stretch runs with no gaps and no stalls.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_edge_normalized;

    import bb3_pkg::*;

    localparam int          LINE_PIXELS        = 1024;
    localparam int          SETTLE_CYCLES      = 8;
    localparam int          WATCHDOG_LIMIT     = 2000;
    localparam cfg_index_t  REG_UNUSED         = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  pixel_valid;
    logic                  pixel_stall;
    pixel_req_t            pixel;
    logic                  blur_valid;
    logic                  blur_stall;
    blur_req_t             blur;

    // scoreboard copy of the block state
    logic [FRAME_WIDTH_W-1:0]  geom_width  = WIDTH_RESET;
    logic [FRAME_HEIGHT_W-1:0] geom_height = HEIGHT_RESET;
    pix_t        upper_line [LINE_PIXELS] = '{default: '0};
    pix_t        middle_line [LINE_PIXELS] = '{default: '0};
    pix_t        window [9] = '{default: '0};
    int unsigned in_col  = 0;
    int unsigned in_row  = 0;
    int unsigned out_col = 0;
    int unsigned out_row = 0;

    blur_req_t   pending_blur [$];

    bit          idling_on      = 1'b1;
    int unsigned error_count    = 0;
    int unsigned results_seen   = 0;
    int unsigned frames_ended   = 0;
    int unsigned items_used     = 0;
    int unsigned drains_ignored = 0;
    int unsigned cfg_writes     = 0;

    box_blur_3x3_edge_normalized #(
        .MAX_LINE_PIXELS (LINE_PIXELS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .blur_valid  (blur_valid),
        .blur_stall  (blur_stall),
        .blur        (blur)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // scoreboard model
    // ------------------------------------------------------------------------

    function automatic int unsigned eff_width();
        int unsigned w;
        w = geom_width;
        if (w < 1) w = 1;
        if (w > LINE_PIXELS) w = LINE_PIXELS;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = geom_height;
        if (h < 1) h = 1;
        if (h > MAX_ROWS) h = MAX_ROWS;
        return h;
    endfunction

    task automatic clear_blur_counters();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endtask

    // advance the model by one accepted pixel request, queue any blur result
    task automatic blur_model_take(input pixel_req_t req);
        int unsigned w, h, c, cnt, sr, sg, sb;
        pix_t        px, top, mid, v;
        bit          emit, up_ok, down_ok, left_ok, right_ok, last;
        blur_req_t   res;
        w = eff_width();
        h = eff_height();
        // drain inside the frame is dropped
        if (in_row < h && req.drain)
        begin
            drains_ignored++;
            return;
        end
        items_used++;
        // past the frame every request acts as a drain, pixel discarded
        px = (in_row < h) ? {req.in_red, req.in_green, req.in_blue} : '0;
        c = (in_col < LINE_PIXELS) ? in_col : LINE_PIXELS - 1;
        top = upper_line[c];
        mid = middle_line[c];
        upper_line[c]  = mid;
        middle_line[c] = px;
        for (int k = 0; k < 6; k++)
            window[k] = window[k + 3];
        window[6] = top;
        window[7] = mid;
        window[8] = px;

        emit = in_row > 1 || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        if (!emit)
            return;

        up_ok    = out_row > 0;
        down_ok  = out_row + 1 < h;
        left_ok  = out_col > 0;
        right_ok = out_col + 1 < w;
        cnt = 0;
        sr  = 0;
        sg  = 0;
        sb  = 0;
        // sum only neighbours inside the frame
        for (int dc = 0; dc < 3; dc++)
        begin
            for (int dr = 0; dr < 3; dr++)
            begin
                if ((dc == 0 && !left_ok) || (dc == 2 && !right_ok) ||
                    (dr == 0 && !up_ok) || (dr == 2 && !down_ok))
                    continue;
                v = window[dc * 3 + dr];
                sr += v.red;
                sg += v.green;
                sb += v.blue;
                cnt++;
            end
        end
        // rounded mean, half up
        res.out_red   = 8'((2 * sr + cnt) / (2 * cnt));
        res.out_green = 8'((2 * sg + cnt) / (2 * cnt));
        res.out_blue  = 8'((2 * sb + cnt) / (2 * cnt));
        last = (out_row + 1 >= h) && (out_col + 1 >= w);
        res.frame_end = last;
        pending_blur.push_back(res);

        if (last)
        begin
            clear_blur_counters();
        end
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    function automatic pixel_req_t pixel_of(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic d);
        pixel_req_t req;
        req.in_red   = r;
        req.in_green = g;
        req.in_blue  = b;
        req.drain    = d;
        return req;
    endfunction

    function automatic pixel_req_t random_pixel(input logic d);
        return pixel_of(8'($urandom), 8'($urandom), 8'($urandom), d);
    endfunction

    // send one pixel request; called at a falling edge, returns at one.
    // valid stays high afterwards so back-to-back requests need no gap.
    task automatic send_pixel(input pixel_req_t req);
        int unsigned gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 11);
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= req;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        @(negedge clk);
        blur_model_take(req);
    endtask

    // stop sending and wait until every predicted result is out
    task automatic wait_results_settle();
        pixel_valid <= 1'b0;
        while (pending_blur.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one register write; valid is dropped only after the last of a sequence
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        if (last)
            cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            REG_FRAME_WIDTH:
            begin
                geom_width = data[FRAME_WIDTH_W-1:0];
                clear_blur_counters();
            end
            REG_FRAME_HEIGHT:
            begin
                geom_height = data[FRAME_HEIGHT_W-1:0];
                clear_blur_counters();
            end
            default: ;
        endcase
    endtask

    task automatic reconfigure(input logic [CFG_DATA_W-1:0] w,
                               input logic [CFG_DATA_W-1:0] h);
        wait_results_settle();
        write_reg(REG_FRAME_WIDTH, w, 1'b0);
        write_reg(REG_FRAME_HEIGHT, h, 1'b1);
    endtask

    // result side stall bursts
    initial
    begin : blur_stall_gen
        int unsigned hold;
        hold = 0;
        blur_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold != 0)
                hold--;
            else if (idling_on && $urandom_range(0, 5) == 0)
                hold = $urandom_range(1, 11);
            blur_stall <= (hold != 0);
        end
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : blur_checker
        blur_req_t want;
        if (rst_n && blur_valid && !blur_stall)
        begin
            if (pending_blur.size() == 0)
            begin
                $error("blur request with no result expected: %h", blur);
                error_count++;
            end
            else
            begin
                want = pending_blur.pop_front();
                results_seen++;
                check_field("out_red", want.out_red, blur.out_red);
                check_field("out_green", want.out_green, blur.out_green);
                check_field("out_blue", want.out_blue, blur.out_blue);
                check_field("frame_end", 8'(want.frame_end), 8'(blur.frame_end));
                if (want.frame_end)
                    frames_ended++;
            end
        end
    end

    // watchdog: ends the run after too long with no handshake at all
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (blur_valid && !blur_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_blur.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // zero geometry clamps to 1x1; two such frames back to back
    task automatic test_single_pixel_frames();
        reconfigure('0, '0);
        send_pixel(pixel_of(8'd255, 8'd255, 8'd255, 1'b0));
        // pixel after the frame counts as a drain
        send_pixel(pixel_of(8'd0, 8'd0, 8'd0, 1'b0));
        send_pixel(pixel_of(8'd0, 8'd0, 8'd0, 1'b1));
        // next frame: a drain inside it is dropped
        send_pixel(pixel_of(8'd9, 8'd9, 8'd9, 1'b1));
        send_pixel(pixel_of(8'd0, 8'd0, 8'd0, 1'b0));
        send_pixel(pixel_of(8'd255, 8'd0, 8'd255, 1'b1));
        send_pixel(pixel_of(8'd1, 8'd2, 8'd3, 1'b0));
    endtask

    // 3x2 frame with dropped drains, an unused register write mid-frame and
    // mixed drain bits after the frame
    task automatic test_frame_edges();
        reconfigure(13'd3, 13'd2);
        send_pixel(pixel_of(8'd0, 8'd0, 8'd0, 1'b0));
        send_pixel(pixel_of(8'd255, 8'd255, 8'd255, 1'b1));
        send_pixel(pixel_of(8'd255, 8'd255, 8'd255, 1'b0));
        send_pixel(pixel_of(8'd255, 8'd0, 8'd128, 1'b0));
        send_pixel(pixel_of(8'd1, 8'd254, 8'd127, 1'b0));
        // unknown index must leave the frame in flight alone
        wait_results_settle();
        write_reg(REG_UNUSED, '1, 1'b1);
        send_pixel(pixel_of(8'd128, 8'd64, 8'd32, 1'b0));
        send_pixel(pixel_of(8'd7, 8'd7, 8'd7, 1'b1));
        send_pixel(pixel_of(8'd255, 8'd255, 8'd255, 1'b0));
        send_pixel(pixel_of(8'd200, 8'd100, 8'd50, 1'b0));
        send_pixel(pixel_of(8'd0, 8'd0, 8'd0, 1'b1));
        send_pixel(pixel_of(8'd255, 8'd255, 8'd255, 1'b0));
        send_pixel(pixel_of(8'd0, 8'd0, 8'd0, 1'b1));
    endtask

    // all-ones register data clamps to 1024 x 4096; then a 1-wide, 4096-tall
    // frame. Both are cut short by the next register write.
    task automatic test_extreme_geometry();
        wait_results_settle();
        write_reg(REG_FRAME_WIDTH, '1, 1'b0);
        write_reg(REG_FRAME_HEIGHT, '1, 1'b1);
        repeat (LINE_PIXELS + 6) send_pixel(random_pixel(1'b0));
        reconfigure(13'd1, MAX_ROWS);
        repeat (12) send_pixel(random_pixel(1'b0));
    endtask

    // random frames, mostly small, some abandoned part way through
    task automatic run_random_frames(input int unsigned target);
        int unsigned start, w, h, n, cut;
        bit          fresh;
        start = items_used;
        fresh = 1'b1;
        while (items_used - start < target)
        begin
            if (fresh || $urandom_range(0, 2) != 0)
            begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64)
                                                : $urandom_range(1, 12);
                reconfigure(CFG_DATA_W'(w), CFG_DATA_W'($urandom_range(1, 8)));
            end
            fresh = 1'b0;
            w = eff_width();
            h = eff_height();
            n = w * h;
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
            for (int k = 0; k < cut; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_pixel(random_pixel(1'b1));
                if ($urandom_range(0, 99) == 0)
                    wait_results_settle();
                send_pixel(random_pixel(1'b0));
            end
            // an abandoned frame is cleared by the next register write
            if (cut < n)
                fresh = 1'b1;
            else
                for (int k = 0; k <= w; k++)
                    send_pixel(random_pixel(1'($urandom)));
        end
    endtask

    task automatic test_random_frames();
        idling_on = 1'b1;
        run_random_frames(450);
    endtask

    task automatic test_steady_stream();
        idling_on = 1'b0;
        run_random_frames(200);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_FRAME_WIDTH;
        cfg_data    = '0;
        pixel_valid = 1'b0;
        pixel       = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_pixel_frames();
        test_frame_edges();
        test_extreme_geometry();
        test_random_frames();
        test_steady_stream();
        wait_results_settle();

        $display("Ran %0d pixel and drain requests (%0d dropped drains), %0d register writes",
                 items_used, drains_ignored, cfg_writes);
        $display("Checked %0d blur results over %0d completed frames; 1024x4096 frames cut short",
                 results_seen, frames_ended);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
